/* hw/rtl/msm_pkg.sv */
// Shared types, codes and default sizes for the multi-source stereo mixer.
// No dependencies; every other file of the block but msm_ram uses it.
`timescale 1ns / 1ps

package msm_pkg;

  localparam int DEF_NUM_SOURCES = 4;
  localparam int DEF_FIFO_FRAMES = 1024;
  localparam int DEF_MIX_FRAMES  = 32;

  localparam int NUM_REGS  = 4;
  localparam int CQ_DEPTH  = 2;  // front-to-back command queue
  localparam int RQ_DEPTH  = 4;  // result queue

  localparam logic       ACT_WRITE = 1'b0;
  localparam logic       ACT_MIX   = 1'b1;
  localparam logic       KIND_WR   = 1'b0;
  localparam logic       KIND_MIX  = 1'b1;
  localparam logic [3:0] CHAN_RESET = 4'd2;

  typedef struct packed {
    logic               is_mix;
    logic [1:0]         source;
    logic signed [15:0] sample;
    logic [10:0]        write_frames;
    logic               silence;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic               write_status;
    logic               frame_valid;
    logic signed [17:0] mix_left;
    logic signed [17:0] mix_right;
    logic               is_last;
  } res_t;

  typedef struct packed {
    logic full;
    logic room2;  // at least two free slots
  } rq_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX_RUN,
    ST_MIX_END
  } state_t;

endpackage

/* hw/rtl/multi_source_stereo_mixer.sv */
// Multi-source stereo mixer: per-source frame FIFOs feeding an exact stereo sum.
// Write request: the back end pops it and queues its status result in the same cycle.
// Mix request: one frame-store read per source and frame for n frames, paused while
// fewer than two result slots are free; n = smallest fill capped at MIX_FRAMES.
// Reset: control state, pointers and fills clear; frame store is not cleared.
// Depends on msm_pkg, msm_front, msm_back, msm_resq, msm_ram.
`timescale 1ns / 1ps

module multi_source_stereo_mixer #(
  parameter int NUM_SOURCES = msm_pkg::DEF_NUM_SOURCES,
  parameter int FIFO_FRAMES = msm_pkg::DEF_FIFO_FRAMES,
  parameter int MIX_FRAMES  = msm_pkg::DEF_MIX_FRAMES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_action,
  input  logic [1:0]         in_source,
  input  logic signed [15:0] in_sample,
  input  logic [10:0]        in_write_frames,
  input  logic               in_silence,
  output logic               empty,
  input  logic               pop,
  output logic               out_kind,
  output logic               out_write_status,
  output logic               out_frame_valid,
  output logic signed [17:0] out_mix_left,
  output logic signed [17:0] out_mix_right,
  output logic               out_is_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  logic              cmd_valid, cmd_pop, res_push;
  msm_pkg::cmd_t     cmd;
  msm_pkg::res_t     res, head;
  msm_pkg::rq_stat_t rq;

  assign cfg_ready = 1'b1;

  msm_front u_front (
    .clk, .rst_n, .push, .full, .in_action, .in_source, .in_sample,
    .in_write_frames, .in_silence, .cmd_valid, .cmd, .cmd_pop
  );

  msm_back #(
    .NUM_SOURCES(NUM_SOURCES), .FIFO_FRAMES(FIFO_FRAMES), .MIX_FRAMES(MIX_FRAMES)
  ) u_back (
    .clk, .rst_n, .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .cmd_valid, .cmd, .cmd_pop, .rq, .res_push, .res
  );

  msm_resq u_resq (
    .clk, .rst_n, .res_push, .res, .stat(rq), .empty, .pop, .head
  );

  assign out_kind         = head.kind;
  assign out_write_status = head.write_status;
  assign out_frame_valid  = head.frame_valid;
  assign out_mix_left     = head.mix_left;
  assign out_mix_right    = head.mix_right;
  assign out_is_last      = head.is_last;

  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && rq.full)) else $error("result queue overflow");

  a_no_cmd_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_pop && !cmd_valid)) else $error("command queue underflow");

  a_mix_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.kind == msm_pkg::KIND_MIX) |-> !res.write_status)
    else $error("mix result with write status set");

endmodule

/* hw/rtl/msm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module msm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/msm_front.sv */
// Front end: accepts input requests, classifies them and queues them for the back end.
// Depends on msm_pkg.
`timescale 1ns / 1ps

module msm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_action,
  input  logic [1:0]         in_source,
  input  logic signed [15:0] in_sample,
  input  logic [10:0]        in_write_frames,
  input  logic               in_silence,
  output logic               cmd_valid,
  output msm_pkg::cmd_t      cmd,
  input  logic               cmd_pop
);

  localparam int QW = $clog2(msm_pkg::CQ_DEPTH);
  localparam int CW = $clog2(msm_pkg::CQ_DEPTH + 1);

  msm_pkg::cmd_t    q_r [msm_pkg::CQ_DEPTH];
  logic [QW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;
  msm_pkg::cmd_t    in_cmd;
  logic             acc;

  assign full      = (cnt_r == CW'(msm_pkg::CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_r];
  assign acc       = push && !full;

  always_comb begin
    in_cmd.is_mix       = (in_action == msm_pkg::ACT_MIX);
    in_cmd.source       = in_source;
    in_cmd.sample       = in_sample;
    in_cmd.write_frames = in_write_frames;
    in_cmd.silence      = in_silence;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (acc) begin
        wr_r <= (wr_r == QW'(msm_pkg::CQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (cmd_pop) begin
        rd_r <= (rd_r == QW'(msm_pkg::CQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(acc) - CW'(cmd_pop);
    end
  end

endmodule

/* hw/rtl/msm_resq.sv */
// Result queue between the back end and the output ports.
// Depends on msm_pkg.
`timescale 1ns / 1ps

module msm_resq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_push,
  input  msm_pkg::res_t     res,
  output msm_pkg::rq_stat_t stat,
  output logic              empty,
  input  logic              pop,
  output msm_pkg::res_t     head
);

  localparam int QW = $clog2(msm_pkg::RQ_DEPTH);
  localparam int CW = $clog2(msm_pkg::RQ_DEPTH + 1);

  msm_pkg::res_t q_r [msm_pkg::RQ_DEPTH];
  logic [QW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          deq;

  assign empty      = (cnt_r == '0);
  assign deq        = pop && !empty;
  assign head       = q_r[rd_r];
  assign stat.full  = (cnt_r == CW'(msm_pkg::RQ_DEPTH));
  assign stat.room2 = (cnt_r <= CW'(msm_pkg::RQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (res_push) begin
        wr_r <= (wr_r == QW'(msm_pkg::RQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (deq) begin
        rd_r <= (rd_r == QW'(msm_pkg::RQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(res_push) - CW'(deq);
    end
  end

endmodule

/* hw/rtl/msm_back.sv */
// Back end: per-source frame FIFOs, write assembly and the mix sequencer.
// Depends on msm_pkg and msm_ram.
`timescale 1ns / 1ps

module msm_back #(
  parameter int NUM_SOURCES = msm_pkg::DEF_NUM_SOURCES,
  parameter int FIFO_FRAMES = msm_pkg::DEF_FIFO_FRAMES,
  parameter int MIX_FRAMES  = msm_pkg::DEF_MIX_FRAMES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              cmd_valid,
  input  msm_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  input  msm_pkg::rq_stat_t rq,
  output logic              res_push,
  output msm_pkg::res_t     res
);

  localparam int SW   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int PW   = $clog2(FIFO_FRAMES);
  localparam int FW   = $clog2(FIFO_FRAMES + 1);
  localparam int NW   = $clog2(MIX_FRAMES + 1);
  localparam int CMPW = (FW > NW) ? FW : NW;
  localparam int SUMW = ((FW > 11) ? FW : 11) + 1;
  localparam int IW   = PW + 1;
  localparam int AW   = SW + PW;
  localparam int ACCW = 17 + SW;
  localparam logic signed [ACCW-1:0] MIX_MAX = ACCW'(131071);
  localparam logic signed [ACCW-1:0] MIX_MIN = -ACCW'(131072);

  logic [3:0]    chan_r [msm_pkg::NUM_REGS];
  logic [PW-1:0] rp_r   [NUM_SOURCES];
  logic [PW-1:0] wp_r   [NUM_SOURCES];
  logic [FW-1:0] fill_r [NUM_SOURCES];
  logic [13:0]   sl_r   [NUM_SOURCES];
  logic          drop_r [NUM_SOURCES];
  logic [2:0]    cif_r  [NUM_SOURCES];
  logic [31:0]   pf_r   [NUM_SOURCES];

  msm_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]   n_r, f_r;
  logic [SW-1:0]   s_r;
  logic            silent_r, rd_v_r, rd_ls_r, rd_lf_r;
  logic signed [ACCW-1:0] accl_r, accr_r;

  // ---- write path ----
  logic          src_ok, wr_go;
  logic [SW-1:0] si;
  logic [3:0]    ch;
  logic [10:0]   frames;
  logic          start, drop, fend, store;
  logic [2:0]    c;
  logic [31:0]   pf, pf_new;
  logic [13:0]   sl_new;

  assign src_ok = (32'(cmd.source) < NUM_SOURCES);
  assign si     = SW'(cmd.source);

  always_comb begin
    ch = chan_r[cmd.source];
    if (ch == 4'd0) begin
      ch = 4'd1;
    end else if (ch > 4'd8) begin
      ch = 4'd8;
    end
    frames = (cmd.write_frames == '0) ? 11'd1 : cmd.write_frames;
    start  = (sl_r[si] == '0);
    drop   = start ? ((SUMW'(fill_r[si]) + SUMW'(frames)) > SUMW'(FIFO_FRAMES))
                   : drop_r[si];
    c      = start ? 3'd0 : cif_r[si];
    pf     = start ? 32'd0 : pf_r[si];
    pf_new = pf;
    if (c == 3'd0) begin
      pf_new = (ch == 4'd1) ? {cmd.sample, cmd.sample} : {pf[31:16], cmd.sample};
    end else if (c == 3'd1) begin
      pf_new = {cmd.sample, pf[15:0]};
    end
    fend   = ({1'b0, c} + 4'd1) >= ch;
    store  = fend && !drop && (fill_r[si] < FW'(FIFO_FRAMES));
    sl_new = (start ? (14'(frames) * 14'(ch)) : sl_r[si]) - 14'd1;
  end

  // ---- mix count ----
  logic [CMPW-1:0] nmin;
  always_comb begin
    nmin = CMPW'(MIX_FRAMES);
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (CMPW'(fill_r[i]) < nmin) begin
        nmin = CMPW'(fill_r[i]);
      end
    end
  end

  // ---- frame store ----
  logic [IW-1:0]   idx;
  logic [AW-1:0]   raddr;
  logic [31:0]     rdata;
  logic            issue;

  assign idx   = IW'(rp_r[s_r]) + IW'(f_r);
  assign raddr = {s_r, (idx >= IW'(FIFO_FRAMES)) ? PW'(idx - IW'(FIFO_FRAMES)) : PW'(idx)};
  assign issue = (state_r == msm_pkg::ST_MIX_RUN) && rq.room2;

  msm_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_store (
    .clk   (clk),
    .we    (wr_go && store),
    .waddr ({si, wp_r[si]}),
    .wdata (pf_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic signed [ACCW-1:0] suml, sumr, satl, satr;
  always_comb begin
    suml = accl_r + ACCW'($signed(rdata[15:0]));
    sumr = accr_r + ACCW'($signed(rdata[31:16]));
    satl = (suml > MIX_MAX) ? MIX_MAX : ((suml < MIX_MIN) ? MIX_MIN : suml);
    satr = (sumr > MIX_MAX) ? MIX_MAX : ((sumr < MIX_MIN) ? MIX_MIN : sumr);
  end

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msm_pkg::ST_IDLE: begin
        if (cmd_valid && !rq.full && cmd.is_mix && (nmin != '0)) begin
          state_nxt = msm_pkg::ST_MIX_RUN;
        end
      end
      msm_pkg::ST_MIX_RUN: begin
        if (issue && (s_r == SW'(NUM_SOURCES - 1)) && (f_r == n_r - 1'b1)) begin
          state_nxt = msm_pkg::ST_MIX_END;
        end
      end
      msm_pkg::ST_MIX_END: state_nxt = msm_pkg::ST_IDLE;
      default:             state_nxt = msm_pkg::ST_IDLE;
    endcase
  end

  // ---- outputs ----
  always_comb begin
    cmd_pop  = 1'b0;
    wr_go    = 1'b0;
    res_push = 1'b0;
    res      = '0;
    res.is_last = 1'b1;
    unique case (state_r)
      msm_pkg::ST_IDLE: begin
        if (cmd_valid && !rq.full) begin
          cmd_pop = 1'b1;
          if (!cmd.is_mix) begin
            wr_go            = src_ok;
            res_push         = 1'b1;
            res.kind         = msm_pkg::KIND_WR;
            res.write_status = src_ok ? drop : 1'b1;
          end else if (nmin == '0) begin
            res_push = 1'b1;
            res.kind = msm_pkg::KIND_MIX;
          end
        end
      end
      msm_pkg::ST_MIX_RUN, msm_pkg::ST_MIX_END: begin
        if (rd_v_r && rd_ls_r) begin
          res_push        = 1'b1;
          res.kind        = msm_pkg::KIND_MIX;
          res.frame_valid = 1'b1;
          res.mix_left    = silent_r ? 18'sd0 : satl[17:0];
          res.mix_right   = silent_r ? 18'sd0 : satr[17:0];
          res.is_last     = rd_lf_r;
        end
      end
      default: ;
    endcase
  end

  // ---- state and datapath registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msm_pkg::ST_IDLE;
      rd_v_r  <= 1'b0;
      for (int i = 0; i < msm_pkg::NUM_REGS; i++) begin
        chan_r[i] <= msm_pkg::CHAN_RESET;
      end
      for (int i = 0; i < NUM_SOURCES; i++) begin
        rp_r[i]   <= '0;
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
        sl_r[i]   <= '0;
        drop_r[i] <= 1'b0;
        cif_r[i]  <= '0;
        pf_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      if (cfg_we) begin
        chan_r[cfg_index] <= cfg_data;
      end
      if (wr_go) begin
        if (store) begin
          wp_r[si]   <= (wp_r[si] == PW'(FIFO_FRAMES - 1)) ? '0 : wp_r[si] + 1'b1;
          fill_r[si] <= fill_r[si] + 1'b1;
        end
        sl_r[si] <= sl_new;
        if (sl_new == '0) begin
          cif_r[si]  <= '0;
          pf_r[si]   <= '0;
          drop_r[si] <= 1'b0;
        end else begin
          cif_r[si]  <= fend ? 3'd0 : c + 3'd1;
          pf_r[si]   <= fend ? 32'd0 : pf_new;
          drop_r[si] <= drop;
        end
      end
      if (state_r == msm_pkg::ST_MIX_END) begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
          rp_r[i] <= ((IW'(rp_r[i]) + IW'(n_r)) >= IW'(FIFO_FRAMES))
                   ? PW'(IW'(rp_r[i]) + IW'(n_r) - IW'(FIFO_FRAMES))
                   : PW'(IW'(rp_r[i]) + IW'(n_r));
          fill_r[i] <= fill_r[i] - FW'(n_r);
        end
      end
    end
  end

  // mix counters and accumulators
  always_ff @(posedge clk) begin
    if (state_r == msm_pkg::ST_IDLE) begin
      n_r      <= NW'(nmin);
      f_r      <= '0;
      s_r      <= '0;
      silent_r <= cmd.silence;
      accl_r   <= '0;
      accr_r   <= '0;
    end else begin
      if (issue) begin
        rd_ls_r <= (s_r == SW'(NUM_SOURCES - 1));
        rd_lf_r <= (f_r == n_r - 1'b1);
        if (s_r == SW'(NUM_SOURCES - 1)) begin
          s_r <= '0;
          f_r <= f_r + 1'b1;
        end else begin
          s_r <= s_r + 1'b1;
        end
      end
      if (rd_v_r) begin
        accl_r <= rd_ls_r ? '0 : suml;
        accr_r <= rd_ls_r ? '0 : sumr;
      end
    end
  end

endmodule

/* bench/multi_source_stereo_mixer_check.sv */
// Checker for the stereo mixer: watches the request, result and register channels,
// predicts every result from its own model of the per-source frame FIFOs and compares.
// Depends on msm_pkg.
`timescale 1ns / 1ps

module multi_source_stereo_mixer_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic               in_action,
  input  logic [1:0]         in_source,
  input  logic signed [15:0] in_sample,
  input  logic [10:0]        in_write_frames,
  input  logic               in_silence,
  input  logic               empty,
  input  logic               pop,
  input  logic               out_kind,
  input  logic               out_write_status,
  input  logic               out_frame_valid,
  input  logic signed [17:0] out_mix_left,
  input  logic signed [17:0] out_mix_right,
  input  logic               out_is_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam int NSRC = msm_pkg::DEF_NUM_SOURCES;
  localparam int DEPTH = msm_pkg::DEF_FIFO_FRAMES;
  localparam int MIXN = msm_pkg::DEF_MIX_FRAMES;

  logic [31:0]   frames_mem [NSRC][DEPTH];
  int            rd_ptr [NSRC];
  int            wr_ptr [NSRC];
  int            fill [NSRC];
  int            samples_left [NSRC];
  logic          dropping [NSRC];
  int            chan_idx [NSRC];
  logic [31:0]   part [NSRC];
  logic [3:0]    chan_reg [msm_pkg::NUM_REGS];
  msm_pkg::res_t expected_q [$];
  int            err_cnt = 0;

  assign errors = err_cnt;

  function automatic msm_pkg::res_t mk_res(logic k, logic st, logic v, int l, int r,
                                           logic last);
    msm_pkg::res_t x;
    x.kind = k;
    x.write_status = st;
    x.frame_valid = v;
    x.mix_left = 18'(l);
    x.mix_right = 18'(r);
    x.is_last = last;
    return x;
  endfunction

  function automatic int sat18(int v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  task automatic predict_write(int s, logic [15:0] smp, int frames);
    int ch;
    int c;
    logic drop;
    ch = (chan_reg[s] == 0) ? 1 : (chan_reg[s] > 8) ? 8 : int'(chan_reg[s]);
    if (samples_left[s] == 0) begin
      if (frames == 0) frames = 1;
      samples_left[s] = frames * ch;
      dropping[s] = (fill[s] + frames) > DEPTH;
      chan_idx[s] = 0;
      part[s] = '0;
    end
    drop = dropping[s];
    c = chan_idx[s];
    if (c == 0) begin
      part[s][15:0] = smp;
      if (ch == 1) part[s] = {smp, smp};
    end else if (c == 1) begin
      part[s][31:16] = smp;
    end
    if (c + 1 >= ch) begin
      if (!drop && fill[s] < DEPTH) begin
        frames_mem[s][wr_ptr[s]] = part[s];
        wr_ptr[s] = (wr_ptr[s] + 1) % DEPTH;
        fill[s]++;
      end
      chan_idx[s] = 0;
      part[s] = '0;
    end else begin
      chan_idx[s] = c + 1;
    end
    samples_left[s]--;
    if (samples_left[s] == 0) begin
      chan_idx[s] = 0;
      part[s] = '0;
      dropping[s] = 1'b0;
    end
    expected_q.push_back(mk_res(msm_pkg::KIND_WR, drop, 1'b0, 0, 0, 1'b1));
  endtask

  task automatic predict_mix(logic silent);
    int n;
    int l;
    int r;
    logic [31:0] w;
    n = MIXN;
    for (int s = 0; s < NSRC; s++) if (fill[s] < n) n = fill[s];
    if (n == 0) begin
      expected_q.push_back(mk_res(msm_pkg::KIND_MIX, 1'b0, 1'b0, 0, 0, 1'b1));
      return;
    end
    for (int f = 0; f < n; f++) begin
      l = 0;
      r = 0;
      for (int s = 0; s < NSRC; s++) begin
        w = frames_mem[s][(rd_ptr[s] + f) % DEPTH];
        l += int'($signed(w[15:0]));
        r += int'($signed(w[31:16]));
      end
      if (silent) begin
        l = 0;
        r = 0;
      end
      expected_q.push_back(mk_res(msm_pkg::KIND_MIX, 1'b0, 1'b1, sat18(l), sat18(r),
                                  f == n - 1));
    end
    for (int s = 0; s < NSRC; s++) begin
      rd_ptr[s] = (rd_ptr[s] + n) % DEPTH;
      fill[s] -= n;
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    msm_pkg::res_t e;
    if (!rst_n) begin
      for (int s = 0; s < NSRC; s++) begin
        rd_ptr[s] = 0;
        wr_ptr[s] = 0;
        fill[s] = 0;
        samples_left[s] = 0;
        dropping[s] = 1'b0;
        chan_idx[s] = 0;
        part[s] = '0;
      end
      for (int i = 0; i < msm_pkg::NUM_REGS; i++) chan_reg[i] = msm_pkg::CHAN_RESET;
      expected_q.delete();
      err_cnt = 0;
      pending <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d left %0d right %0d",
                   $time, out_kind, out_mix_left, out_mix_right);
          err_cnt++;
        end else begin
          e = expected_q.pop_front();
          check_field("kind", e.kind, out_kind);
          check_field("write_status", e.write_status, out_write_status);
          check_field("frame_valid", e.frame_valid, out_frame_valid);
          check_field("mix_left", e.mix_left, out_mix_left);
          check_field("mix_right", e.mix_right, out_mix_right);
          check_field("is_last", e.is_last, out_is_last);
        end
      end
      if (cfg_valid && cfg_ready) chan_reg[cfg_index] = cfg_data;
      if (push && !full) begin
        if (in_action == msm_pkg::ACT_MIX) predict_mix(in_silence);
        else predict_write(in_source, in_sample, in_write_frames);
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* bench/multi_source_stereo_mixer_test.sv */
// Top of the stereo mixer bench: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on msm_pkg and the checker module.
`timescale 1ns / 1ps

module multi_source_stereo_mixer_test;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               in_action = msm_pkg::ACT_WRITE;
  logic [1:0]         in_source = '0;
  logic signed [15:0] in_sample = '0;
  logic [10:0]        in_write_frames = '0;
  logic               in_silence = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic               out_kind;
  logic               out_write_status;
  logic               out_frame_valid;
  logic signed [17:0] out_mix_left;
  logic signed [17:0] out_mix_right;
  logic               out_is_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [3:0]         cfg_data = '0;
  int                 errors;
  int                 pending;

  int                 tx_idle_pct = 0;
  int                 rx_stall_pct = 0;
  logic [3:0]         chan_now [msm_pkg::NUM_REGS] = '{msm_pkg::CHAN_RESET,
                        msm_pkg::CHAN_RESET, msm_pkg::CHAN_RESET, msm_pkg::CHAN_RESET};

  always #5 clk = ~clk;

  multi_source_stereo_mixer i_dut (.*);
  multi_source_stereo_mixer_check i_check (.*);

  always @(posedge clk) pop <= ($urandom_range(99) >= rx_stall_pct);

  task automatic send(logic act, logic [1:0] src, logic [15:0] smp, logic [10:0] frames,
                      logic sil);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    push <= 1'b1;
    in_action <= act;
    in_source <= src;
    in_sample <= smp;
    in_write_frames <= frames;
    in_silence <= sil;
    do @(posedge clk); while (full);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_chans(logic [3:0] c0, logic [3:0] c1, logic [3:0] c2, logic [3:0] c3);
    logic [3:0] v [msm_pkg::NUM_REGS];
    v = '{c0, c1, c2, c3};
    for (int i = 0; i < msm_pkg::NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= v[i];
      do @(posedge clk); while (!cfg_ready);
      chan_now[i] = v[i];
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int chans_of(int s);
    return (chan_now[s] == 0) ? 1 : (chan_now[s] > 8) ? 8 : int'(chan_now[s]);
  endfunction

  // one well-formed write request sequence, sometimes cut short
  task automatic random_write(output int sent);
    int s;
    int fr;
    int n;
    s = $urandom_range(3);
    fr = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
    n = ((fr == 0) ? 1 : fr) * chans_of(s);
    if ($urandom_range(9) == 0) n = $urandom_range(1, n);
    for (int i = 0; i < n; i++)
      send(msm_pkg::ACT_WRITE, 2'(s), 16'($urandom), (i == 0) ? 11'(fr) : 11'($urandom),
           1'($urandom));
    sent = n;
  endtask

  initial begin
    int sent;
    int n;
    logic [3:0] cfgs [4][4];
    cfgs = '{'{4'd1, 4'd2, 4'd8, 4'd3}, '{4'd0, 4'd15, 4'd1, 4'd2},
             '{4'd8, 4'd8, 4'd8, 4'd8}, '{4'd2, 4'd1, 4'd4, 4'd7}};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme samples, zero frame count, empty mix, silence mix
    send(msm_pkg::ACT_WRITE, 2'd0, 16'h8000, 11'd0, 1'b0);
    send(msm_pkg::ACT_WRITE, 2'd0, 16'h7FFF, 11'h7FF, 1'b1);
    send(msm_pkg::ACT_WRITE, 2'd1, 16'h7FFF, 11'd1, 1'b0);
    send(msm_pkg::ACT_WRITE, 2'd1, 16'h7FFF, 11'd1, 1'b0);
    send(msm_pkg::ACT_WRITE, 2'd2, 16'h8000, 11'd1, 1'b0);
    send(msm_pkg::ACT_WRITE, 2'd2, 16'h8000, 11'd1, 1'b0);
    send(msm_pkg::ACT_WRITE, 2'd3, 16'h0000, 11'd1, 1'b0);
    send(msm_pkg::ACT_WRITE, 2'd3, 16'hFFFF, 11'd1, 1'b0);
    send(msm_pkg::ACT_MIX, 2'd3, 16'h1234, 11'd5, 1'b0);
    send(msm_pkg::ACT_MIX, 2'd0, 16'h0000, 11'd0, 1'b0);
    for (int s = 0; s < 4; s++) begin
      send(msm_pkg::ACT_WRITE, 2'(s), 16'h8000, 11'd1, 1'b0);
      send(msm_pkg::ACT_WRITE, 2'(s), 16'h8000, 11'd1, 1'b0);
    end
    send(msm_pkg::ACT_MIX, 2'd0, 16'h0000, 11'd0, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      set_chans(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3]);
      tx_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 6 : 0;
      rx_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 6 : 0;
      n = 0;
      while (n < 48) begin
        if ($urandom_range(99) < 15) begin
          send(msm_pkg::ACT_MIX, 2'($urandom), 16'($urandom), 11'($urandom), 1'($urandom));
          n++;
        end else begin
          random_write(sent);
          n += sent;
        end
        if (ph == 2 && n >= 25 && n < 35) begin
          push <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
          n = 35;
        end
      end
    end

    // oversized write that cannot fit is dropped; then a write of FIFO depth frames
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    wait_drained();
    set_chans(4'd2, 4'd2, 4'd2, 4'd2);
    send(msm_pkg::ACT_WRITE, 2'd0, 16'h5555, 11'h7FF, 1'b0);
    send(msm_pkg::ACT_WRITE, 2'd0, 16'hAAAA, 11'd1, 1'b0);
    send(msm_pkg::ACT_WRITE, 2'd1, 16'h0001, 11'd1024, 1'b0);
    send(msm_pkg::ACT_WRITE, 2'd1, 16'h0002, 11'd1, 1'b0);
    send(msm_pkg::ACT_MIX, 2'd0, 16'h0000, 11'd0, 1'b0);

    wait_drained();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* multi_source_stereo_mixer.f */
hw/rtl/msm_pkg.sv
hw/rtl/msm_ram.sv
hw/rtl/msm_front.sv
hw/rtl/msm_resq.sv
hw/rtl/msm_back.sv
hw/rtl/multi_source_stereo_mixer.sv
bench/multi_source_stereo_mixer_check.sv
bench/multi_source_stereo_mixer_test.sv
